>>> src/lelm_pkg.sv
// Package for the LRU entry list manager: operation and status codes, payload types.
// No dependencies.
package lelm_pkg;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_ATTACH = 2'd1;
   localparam logic [1:0] OP_DETACH = 2'd2;
   localparam logic [1:0] OP_DELETE = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FREE = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [5:0]  slot_index;
      logic [31:0] entry_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  result_index;
      logic        list_nonempty;
      logic [5:0]  newest_index;
      logic [5:0]  oldest_index;
      logic [31:0] total_bytes;
      logic [31:0] eviction_count;
   } rsp_type;

endpackage

>>> src/lelm_req_if.sv
// Request channel interface: valid/ready handshake carrying one operation.
// Depends on lelm_pkg.
interface lelm_req_if import lelm_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> src/lelm_rsp_if.sv
// Response channel interface: valid/ready handshake carrying one result.
// Depends on lelm_pkg.
interface lelm_rsp_if import lelm_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> src/lru_entry_list_manager_top.sv
// LRU entry list manager.
// Channels: req (op, slot_index, entry_length) in, rsp (one result per request) out,
// csr write port that loads the running byte total.
// Each transaction runs through a small sequencer around two synchronous link memories
// (next and prev) plus length and reference count memories, all with registered reads.
// Steps from accept to response valid: read the request, then execute on the slot's
// own links; delete and attach then rewrite the neighbors, attach then the head, on the
// single write port of each link memory; free-slot and full-pool errors skip straight
// to the response.
// Throughput: one transaction at a time; the next is accepted once the response register
// is free, so a stalled receiver holds the block with the response parked in rsp.
// Free-slot search scans a 64-bit used mask with a priority encoder.
// Reset: synchronous, clears the used mask, head/tail to null, byte total and
// eviction count; link and data memories are not cleared (never read before written).
// Depends on lelm_pkg, lelm_req_if, lelm_rsp_if.
module lru_entry_list_manager_top import lelm_pkg::*; #(
   parameter int ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   lelm_req_if.sink    req,
   lelm_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);
   localparam int IW = $clog2(ENTRIES);
   localparam int LW = IW + 1;
   localparam logic [LW-1:0] NIL = LW'(ENTRIES);

   localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_EXEC = 3'd2, S_LINK2 = 3'd3,
                          S_LINK3 = 3'd4, S_RESP = 3'd5;

   logic [LW-1:0] next_mem [ENTRIES];
   logic [LW-1:0] prev_mem [ENTRIES];
   logic [31:0]   len_mem  [ENTRIES];
   logic [15:0]   ref_mem  [ENTRIES];

   logic [ENTRIES-1:0] used_ff, used_in;
   logic [LW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [31:0] total_ff, total_in, evict_ff, evict_in;
   logic [2:0] state_ff, state_in;
   req_type req_ff, req_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [1:0] status_ff, status_in;
   logic [LW-1:0] nx_ff, nx_in, pv_ff, pv_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [IW-1:0] rd_addr;
   logic [LW-1:0] next_rd, prev_rd;
   logic [31:0] len_rd;
   logic [15:0] ref_rd;

   logic          nw_en, pw_en, lw_en, rw_en;
   logic [IW-1:0] nw_addr, pw_addr;
   logic [LW-1:0] nw_data, pw_data;
   logic [15:0]   rw_data;

   logic          found;
   logic [IW-1:0] free_idx;
   logic          live;

   always_comb begin
      found = 1'b0;
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            found = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   // out-of-range index (only when ENTRIES < 64) counts as a free slot
   always_comb begin
      live = 1'b0;
      if (int'(req_ff.slot_index) < ENTRIES)
         live = used_ff[IW'(req_ff.slot_index)];
   end

   always_ff @(posedge clock) begin
      if (nw_en) next_mem[nw_addr] <= nw_data;
      if (pw_en) prev_mem[pw_addr] <= pw_data;
      if (lw_en) len_mem[idx_ff] <= req_ff.entry_length;
      if (rw_en) ref_mem[idx_ff] <= rw_data;
      next_rd <= next_mem[rd_addr];
      prev_rd <= prev_mem[rd_addr];
      len_rd  <= len_mem[rd_addr];
      ref_rd  <= ref_mem[rd_addr];
   end

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      idx_in = idx_ff;
      status_in = status_ff;
      nx_in = nx_ff;
      pv_in = pv_ff;
      used_in = used_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      total_in = total_ff;
      evict_in = evict_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      rd_addr = idx_ff;
      nw_en = 1'b0; pw_en = 1'b0; lw_en = 1'b0; rw_en = 1'b0;
      nw_addr = idx_ff; pw_addr = idx_ff;
      nw_data = NIL; pw_data = NIL;
      rw_data = ref_rd;

      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      if (csr_we) total_in = csr_wdata;

      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               req_in = req.data;
               state_in = S_READ;
            end
         end
         S_READ: begin
            idx_in = IW'(req_ff.slot_index);
            status_in = ST_OK;
            if (req_ff.op == OP_ADD) begin
               if (!found) begin
                  status_in = ST_FULL;
                  state_in = S_RESP;
               end else begin
                  idx_in = free_idx;
                  state_in = S_EXEC;
               end
            end else if (!live) begin
               status_in = ST_FREE;
               state_in = S_RESP;
            end else begin
               state_in = S_EXEC;
            end
            rd_addr = idx_in;
         end
         S_EXEC: begin
            // memory read data for idx_ff is valid here
            nx_in = next_rd;
            pv_in = prev_rd;
            state_in = S_RESP;
            case (req_ff.op)
               OP_ADD: begin
                  used_in[idx_ff] = 1'b1;
                  nw_en = 1'b1; pw_en = 1'b1; lw_en = 1'b1; rw_en = 1'b1;
                  rw_data = '0;
                  total_in = total_ff + req_ff.entry_length;
               end
               OP_DETACH: begin
                  rw_en = 1'b1;
                  rw_data = ref_rd - 16'd1;
               end
               OP_ATTACH: begin
                  rw_en = 1'b1;
                  rw_data = ref_rd + 16'd1;
                  state_in = S_LINK2;
               end
               default: begin
                  used_in[idx_ff] = 1'b0;
                  total_in = total_ff - len_rd;
                  evict_in = evict_ff + 32'd1;
                  state_in = S_LINK2;
               end
            endcase
         end
         S_LINK2: begin
            // unlink: prev[nx] = pv, next[pv] = nx, fix head/tail
            if (head_ff == {1'b0, idx_ff}) head_in = nx_ff;
            if (tail_ff == {1'b0, idx_ff}) tail_in = pv_ff;
            if (nx_ff < NIL) begin
               pw_en = 1'b1; pw_addr = nx_ff[IW-1:0]; pw_data = pv_ff;
            end
            if (pv_ff < NIL) begin
               nw_en = 1'b1; nw_addr = pv_ff[IW-1:0]; nw_data = nx_ff;
            end
            state_in = (req_ff.op == OP_ATTACH) ? S_LINK3 : S_RESP;
         end
         S_LINK3: begin
            // push front using updated head
            if (head_ff < NIL) begin
               pw_en = 1'b1; pw_addr = head_ff[IW-1:0]; pw_data = {1'b0, idx_ff};
            end
            nw_en = 1'b1; nw_data = head_ff;
            head_in = {1'b0, idx_ff};
            if (tail_ff >= NIL) tail_in = {1'b0, idx_ff};
            state_in = S_RESP;
         end
         S_RESP: begin
            // prev[idx] = NIL for attach lands here on the free port
            if (req_ff.op == OP_ATTACH && status_ff == ST_OK) begin
               pw_en = 1'b1; pw_addr = idx_ff; pw_data = NIL;
            end
            rsp_valid_in = 1'b1;
            rsp_in.status = status_ff;
            rsp_in.result_index = (req_ff.op == OP_ADD)
               ? ((status_ff == ST_OK) ? 6'(idx_ff) : 6'd0) : req_ff.slot_index;
            rsp_in.list_nonempty = head_ff < NIL;
            rsp_in.newest_index = (head_ff < NIL) ? 6'(head_ff) : 6'd0;
            rsp_in.oldest_index = (tail_ff < NIL) ? 6'(tail_ff) : 6'd0;
            rsp_in.total_bytes = total_ff;
            rsp_in.eviction_count = evict_ff;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         head_ff <= NIL;
         tail_ff <= NIL;
         total_ff <= '0;
         evict_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         total_ff <= total_in;
         evict_ff <= evict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      idx_ff <= idx_in;
      status_ff <= status_in;
      nx_ff <= nx_in;
      pv_ff <= pv_in;
      rsp_ff <= rsp_in;
   end

endmodule

>>> sim/lelm_checker.sv
// Checker for the LRU entry list manager: watches req/rsp transactions, predicts
// each response with its own list model and compares. Depends on lelm_pkg.
module lelm_checker import lelm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   localparam int NSLOT = 64;
   localparam logic [6:0] NIL = 7'd64;

   logic        used [NSLOT];
   logic [6:0]  nxt [NSLOT];
   logic [6:0]  prv [NSLOT];
   logic [31:0] len [NSLOT];
   logic [15:0] refs [NSLOT];
   logic [6:0]  head, tail;
   logic [31:0] bytes_sum, evict_sum;
   rsp_type     expected_rsp[$];

   assign pending = expected_rsp.size();

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   task automatic unlink_slot(input logic [6:0] i);
      logic [6:0] nx, pv;
      nx = nxt[i];
      pv = prv[i];
      if (head == i) head = nx;
      if (tail == i) tail = pv;
      if (nx < NIL) prv[nx[5:0]] = pv;
      if (pv < NIL) nxt[pv[5:0]] = nx;
   endtask

   task automatic predict_list_op(input req_type r);
      rsp_type e;
      logic [6:0] idx, found;
      idx = {1'b0, r.slot_index};
      e.status = ST_OK;
      e.result_index = r.slot_index;
      if (r.op == OP_ADD) begin
         found = NIL;
         for (int i = NSLOT - 1; i >= 0; i--)
            if (!used[i]) found = 7'(i);
         if (found == NIL) begin
            e.status = ST_FULL;
            e.result_index = '0;
         end else begin
            used[found] = 1'b1;
            nxt[found] = NIL;
            prv[found] = NIL;
            len[found] = r.entry_length;
            refs[found] = '0;
            bytes_sum += r.entry_length;
            e.result_index = found[5:0];
         end
      end else if (!used[idx]) begin
         e.status = ST_FREE;
      end else if (r.op == OP_ATTACH) begin
         unlink_slot(idx);
         if (head < NIL) prv[head[5:0]] = idx;
         prv[idx] = NIL;
         nxt[idx] = head;
         head = idx;
         if (tail >= NIL) tail = idx;
         refs[idx]++;
      end else if (r.op == OP_DETACH) begin
         refs[idx]--;
      end else begin
         unlink_slot(idx);
         bytes_sum -= len[idx];
         evict_sum++;
         used[idx] = 1'b0;
      end
      e.list_nonempty = head < NIL;
      e.newest_index = (head < NIL) ? head[5:0] : 6'd0;
      e.oldest_index = (tail < NIL) ? tail[5:0] : 6'd0;
      e.total_bytes = bytes_sum;
      e.eviction_count = evict_sum;
      expected_rsp.push_back(e);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSLOT; i++) used[i] = 1'b0;
         head = NIL;
         tail = NIL;
         bytes_sum = '0;
         evict_sum = '0;
         expected_rsp.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               report("unexpected transaction", '0, '0);
            end else begin
               rsp_type w;
               w = expected_rsp.pop_front();
               if (rsp_data.status != w.status) report("status", rsp_data.status, w.status);
               if (rsp_data.result_index != w.result_index)
                  report("result_index", rsp_data.result_index, w.result_index);
               if (rsp_data.list_nonempty != w.list_nonempty)
                  report("list_nonempty", rsp_data.list_nonempty, w.list_nonempty);
               if (rsp_data.newest_index != w.newest_index)
                  report("newest_index", rsp_data.newest_index, w.newest_index);
               if (rsp_data.oldest_index != w.oldest_index)
                  report("oldest_index", rsp_data.oldest_index, w.oldest_index);
               if (rsp_data.total_bytes != w.total_bytes)
                  report("total_bytes", rsp_data.total_bytes, w.total_bytes);
               if (rsp_data.eviction_count != w.eviction_count)
                  report("eviction_count", rsp_data.eviction_count, w.eviction_count);
            end
         end
         if (req_valid && req_ready) predict_list_op(req_data);
         if (csr_we) bytes_sum = csr_wdata;
      end
   end
endmodule

>>> sim/tb_lru_entry_list_manager_top.sv
// Testbench top for lru_entry_list_manager_top: drives requests, stalls responses,
// writes the byte total register between phases. Depends on lelm_pkg,
// lelm_req_if, lelm_rsp_if and lelm_checker.
module tb_lru_entry_list_manager_top;
   import lelm_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;
   int          fail_count, pending;
   int          sent, rsp_seen;
   int          rsp_wait;

   lelm_req_if req ();
   lelm_rsp_if rsp ();

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
   end

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   lru_entry_list_manager_top dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   lelm_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   // one full transaction: random gap, then hold valid until accepted;
   // valid stays high after accept so a zero gap runs back to back
   task automatic send_op(input logic [1:0] op, input logic [5:0] idx, input logic [31:0] len,
                          input bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18));
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data <= '{op: op, slot_index: idx, entry_length: len};
      do @(posedge clock); while (!req.ready);
      sent++;
   endtask

   // stop sending and wait until every expected response has come back
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_start_bytes(input logic [31:0] v);
      drain();
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] rand_len();
      case ($urandom_range(0, 3))
         0: return 32'hFFFF_FFFF;
         1: return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   // response side stall: ready is held low for a random wait per transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         rsp_wait = $urandom_range(0, 18);
      end else if (rsp.valid && rsp.ready) begin
         rsp_seen++;
         rsp_wait = $urandom_range(0, 18);
         rsp.ready <= (rsp_wait == 0);
      end else if (rsp.valid && !rsp.ready) begin
         if (rsp_wait > 0) rsp_wait--;
         rsp.ready <= (rsp_wait == 0);
      end
   end

   initial begin
      #2_000_000;
      $display("lru_entry_list_manager_top test failed");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_start_bytes(32'hFFFF_FFF0);
      // directed: wrap on add, free-slot ops, attach of unlinked, detach at zero
      send_op(OP_DETACH, 6'd0, '0);
      send_op(OP_DELETE, 6'd63, '0);
      send_op(OP_ATTACH, 6'd5, '0);
      send_op(OP_ADD, 6'd63, 32'hFFFF_FFFF);
      send_op(OP_ADD, 6'd0, 32'd32);
      send_op(OP_DETACH, 6'd0, '0);
      send_op(OP_ATTACH, 6'd0, '0);
      send_op(OP_ATTACH, 6'd1, '0);
      send_op(OP_ATTACH, 6'd0, '0);
      send_op(OP_DELETE, 6'd0, '0);
      send_op(OP_DELETE, 6'd1, '0);
      // fill the pool, then add to a full pool
      for (int i = 0; i < 65; i++) send_op(OP_ADD, 6'(i), $urandom, 1);
      send_op(OP_ATTACH, 6'd63, '0);
      send_op(OP_ATTACH, 6'd0, '0);
      send_op(OP_DELETE, 6'd63, '0);
      write_start_bytes(32'h0);
      // random phases; adds outweigh deletes to keep the list busy
      for (int ph = 0; ph < 4; ph++) begin
         for (int n = 0; n < 310; n++) begin
            logic [1:0] op;
            int r;
            r = $urandom_range(0, 9);
            op = (r < 3) ? OP_ADD : (r < 7) ? OP_ATTACH : (r < 8) ? OP_DETACH : OP_DELETE;
            // mostly low slots so operations hit live entries
            send_op(op, ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 15)),
                    rand_len());
            if (n == 150) drain();
         end
         write_start_bytes(ph == 0 ? 32'hFFFF_FFFF : $urandom);
      end
      drain();
      repeat (20) @(posedge clock);
      $display("Covered %0d requests and %0d responses: free-slot errors, full pool,", sent,
               rsp_seen);
      $display("move-to-front, counter wrap and byte total reloads.");
      if (fail_count == 0)
         $display("lru_entry_list_manager_top test passed");
      else
         $display("lru_entry_list_manager_top test failed");
      $finish;
   end
endmodule
